### hdl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// LRU page cache policy package
// Shared widths, register indexes, result codes, state and control types.
// ----------------------------------------------------------------------------
package lpc_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int PAGE_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int EIU_W    = 5;
   localparam int APB_AW   = 3;
   localparam int APB_DW   = 32;

   localparam logic [EIU_W-1:0] EIU_RESET = 5'd16;

   // Register index is taken from paddr[2].
   localparam logic CSR_IDX_ENTRIES = 1'b0;
   localparam logic CSR_IDX_LIMIT   = 1'b1;

   localparam logic [STATUS_W-1:0] RS_HIT   = 2'd0;
   localparam logic [STATUS_W-1:0] RS_FILL  = 2'd1;
   localparam logic [STATUS_W-1:0] RS_EVICT = 2'd2;
   localparam logic [STATUS_W-1:0] RS_RANGE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_END,
      ST_DECIDE,
      ST_UPDATE,
      ST_UPDATE_END
   } state_type;

   typedef struct packed {
      logic load;
      logic search_rd;
      logic search_acc;
      logic decide;
      logic upd_rd;
      logic upd_wr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic err;
   } dp_stat_type;

endpackage

### hdl/lpc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/lpc_csr.sv
// ----------------------------------------------------------------------------
// LRU page cache configuration registers
// APB-style register file holding the entry limit and the page limit.
// ----------------------------------------------------------------------------
module lpc_csr import lpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready,
   output logic [EIU_W-1:0]  entries_in_use,
   output logic [PAGE_W-1:0] page_limit
);

   logic [EIU_W-1:0]  eiu_ff, eiu_in;
   logic [PAGE_W-1:0] limit_ff, limit_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      eiu_in   = eiu_ff;
      limit_in = limit_ff;
      if (wr_en) begin
         unique case (paddr[2])
            CSR_IDX_ENTRIES: eiu_in   = pwdata[EIU_W-1:0];
            CSR_IDX_LIMIT:   limit_in = pwdata[PAGE_W-1:0];
            default:         eiu_in   = eiu_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff   <= EIU_RESET;
         limit_ff <= '0;
      end else begin
         eiu_ff   <= eiu_in;
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_IDX_ENTRIES: prdata = APB_DW'(eiu_ff);
         CSR_IDX_LIMIT:   prdata = APB_DW'(limit_ff);
         default:         prdata = '0;
      endcase
   end

   assign entries_in_use = eiu_ff;
   assign page_limit     = limit_ff;

endmodule

### hdl/lpc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page cache controller
// Sequences the tag search sweep, the decision and the recency update sweep.
// ----------------------------------------------------------------------------
module lpc_ctrl import lpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (start) state_in = ST_SEARCH;
         ST_SEARCH:     if (stat.scan_last) state_in = ST_SEARCH_END;
         ST_SEARCH_END: state_in = ST_DECIDE;
         ST_DECIDE:     state_in = stat.err ? ST_IDLE : ST_UPDATE;
         ST_UPDATE:     if (stat.scan_last) state_in = ST_UPDATE_END;
         ST_UPDATE_END: state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:       cmd.load = start;
         ST_SEARCH: begin
            cmd.search_rd  = 1'b1;
            cmd.search_acc = 1'b1;
         end
         ST_SEARCH_END: cmd.search_acc = 1'b1;
         ST_DECIDE:     cmd.decide = 1'b1;
         ST_UPDATE: begin
            cmd.upd_rd = 1'b1;
            cmd.upd_wr = 1'b1;
         end
         ST_UPDATE_END: cmd.upd_wr = 1'b1;
         default:       cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // A request is only taken from idle.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE)
      else $error("load issued outside idle");

   // The update sweep never follows a rejected request.
   a_err_skip: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && stat.err) |=> !busy)
      else $error("update sweep after out-of-range request");

   // Search always runs into the decision step.
   a_search_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH_END |=> state_ff == ST_DECIDE)
      else $error("search end not followed by decision");

endmodule

### hdl/lpc_datapath.sv
// ----------------------------------------------------------------------------
// LRU page cache datapath
// Tag and rank memories, valid bits, search accumulators and result register.
// ----------------------------------------------------------------------------
module lpc_datapath import lpc_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_stat_type         stat,
   input  logic [PAGE_W-1:0]   req_page_number,
   input  logic [EIU_W-1:0]    entries_in_use,
   input  logic [PAGE_W-1:0]   page_limit,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [PAGE_W-1:0]   rsp_evicted_page
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RW = AW;
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int LW = (FW > EIU_W) ? FW : EIU_W;

   // Scan pointer and the index whose read data arrives this cycle.
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       idx_ff;
   logic                pend_ff;

   logic [PAGE_W-1:0]   page_ff;
   logic                found_ff, found_in;
   logic [AW-1:0]       hit_slot_ff, hit_slot_in;
   logic [RW-1:0]       hit_rank_ff, hit_rank_in;
   logic                free_ff, free_in;
   logic [AW-1:0]       free_slot_ff, free_slot_in;
   logic                any_ff, any_in;
   logic [RW-1:0]       best_ff, best_in;
   logic [AW-1:0]       vic_slot_ff, vic_slot_in;
   logic [PAGE_W-1:0]   vic_tag_ff, vic_tag_in;

   logic [AW-1:0]       sel_ff;
   logic [RW-1:0]       below_ff;
   logic                age_all_ff;

   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [FW-1:0]       fill_ff, fill_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [PAGE_W-1:0]   rsp_evict_ff;

   logic [PAGE_W-1:0]   tag_rdata;
   logic [RW-1:0]       rank_rdata;
   logic [RW-1:0]       rank_wdata;
   logic                acc_en, wr_en, cur_valid;

   logic [LW-1:0]       eff_limit;
   logic                room, err_c, take_free, evict_c, free_path;
   logic [AW-1:0]       sel_c;
   logic [STATUS_W-1:0] status_c;

   lpc_ram #(.WIDTH(PAGE_W), .DEPTH(CAPACITY)) u_tag_ram (
      .clock (clock),
      .we    (cmd.decide & (take_free | evict_c)),
      .waddr (sel_c),
      .wdata (page_ff),
      .raddr (cnt_ff),
      .rdata (tag_rdata)
   );

   lpc_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_rank_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (idx_ff),
      .wdata (rank_wdata),
      .raddr (cnt_ff),
      .rdata (rank_rdata)
   );

   assign acc_en    = cmd.search_acc & pend_ff;
   assign wr_en     = cmd.upd_wr & pend_ff;
   assign cur_valid = valid_ff[idx_ff];

   assign stat.scan_last = (cnt_ff == AW'(CAPACITY - 1));
   assign stat.err       = err_c;

   // Entry limit zero acts as one; values above the capacity act as the capacity.
   always_comb begin
      eff_limit = LW'(entries_in_use);
      if (eff_limit == '0) begin
         eff_limit = LW'(1);
      end else if (eff_limit > LW'(CAPACITY)) begin
         eff_limit = LW'(CAPACITY);
      end
   end

   // The decision works on the accumulated search results.
   always_comb begin
      room      = (LW'(fill_ff) < eff_limit);
      err_c     = !found_ff && ((page_ff == '0) || (page_ff > page_limit));
      free_path = room && free_ff;
      take_free = !found_ff && !err_c && (free_path || !any_ff);
      evict_c   = !found_ff && !err_c && !take_free;
      priority if (found_ff) begin
         sel_c    = hit_slot_ff;
         status_c = RS_HIT;
      end else if (err_c) begin
         sel_c    = '0;
         status_c = RS_RANGE;
      end else if (take_free) begin
         sel_c    = free_path ? free_slot_ff : '0;
         status_c = RS_FILL;
      end else begin
         sel_c    = vic_slot_ff;
         status_c = RS_EVICT;
      end
   end

   // Search accumulators: first hit, first free slot, oldest valid entry.
   always_comb begin
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      hit_slot_in  = hit_slot_ff;
      hit_rank_in  = hit_rank_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      vic_slot_in  = vic_slot_ff;
      vic_tag_in   = vic_tag_ff;
      if (cmd.load || cmd.decide) begin
         cnt_in = '0;
      end else if (cmd.search_rd || cmd.upd_rd) begin
         cnt_in = cnt_ff + AW'(1);
      end
      if (cmd.load) begin
         found_in = 1'b0;
         free_in  = 1'b0;
         any_in   = 1'b0;
      end else if (acc_en) begin
         if (!found_ff && cur_valid && (tag_rdata == page_ff)) begin
            found_in    = 1'b1;
            hit_slot_in = idx_ff;
            hit_rank_in = rank_rdata;
         end
         if (!free_ff && !cur_valid) begin
            free_in      = 1'b1;
            free_slot_in = idx_ff;
         end
         if (cur_valid && (!any_ff || (rank_rdata > best_ff))) begin
            any_in      = 1'b1;
            best_in     = rank_rdata;
            vic_slot_in = idx_ff;
            vic_tag_in  = tag_rdata;
         end
      end
   end

   // Recency update: the chosen slot becomes newest, younger valid entries age.
   always_comb begin
      if (idx_ff == sel_ff) begin
         rank_wdata = '0;
      end else if (cur_valid && (age_all_ff || (rank_rdata < below_ff))) begin
         rank_wdata = rank_rdata + RW'(1);
      end else begin
         rank_wdata = rank_rdata;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      if (cmd.decide && take_free) begin
         valid_in[sel_c] = 1'b1;
         fill_in         = free_path ? fill_ff + FW'(1) : FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= cmd.search_rd | cmd.upd_rd;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= cmd.decide;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= cnt_ff;
      found_ff     <= found_in;
      hit_slot_ff  <= hit_slot_in;
      hit_rank_ff  <= hit_rank_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      any_ff       <= any_in;
      best_ff      <= best_in;
      vic_slot_ff  <= vic_slot_in;
      vic_tag_ff   <= vic_tag_in;
      if (cmd.load) begin
         page_ff <= req_page_number;
      end
      if (cmd.decide) begin
         sel_ff        <= sel_c;
         below_ff      <= hit_rank_ff;
         age_all_ff    <= !found_ff;
         rsp_status_ff <= status_c;
         rsp_slot_ff   <= SLOT_W'(sel_c);
         rsp_evict_ff  <= evict_c ? vic_tag_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_evicted_page = rsp_evict_ff;

   // The fill count always matches the number of valid entries.
   a_fill_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(fill_ff))
      else $error("fill count differs from valid entries");

   // A result strobe lasts a single cycle.
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // Rejected requests report slot zero and no evicted page.
   a_range_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == RS_RANGE)) |->
         (rsp_slot_ff == '0) && (rsp_evict_ff == '0))
      else $error("out-of-range result carries data");

   // Only an eviction names an evicted page.
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != RS_EVICT)) |-> (rsp_evict_ff == '0))
      else $error("evicted page reported without eviction");

endmodule

### hdl/lru_page_cache_policy.sv
// ----------------------------------------------------------------------------
// LRU page cache policy
// Fully associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Flow: after start is accepted the tag search sweep runs, then the decision step
// registers the result and raises the result strobe; the rank update sweep follows.
// A new request is taken only from idle, once the rank update sweep has ended
// (or after the decision step when out of range); both sweeps read one entry per
// cycle through the single read port of the tag and rank memories.
// Reset clears all valid bits and the fill count; no clearing pass is needed.
// The result is shown for one cycle and cannot be stalled by the receiver.
module lru_page_cache_policy import lpc_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [PAGE_W-1:0]   req_page_number,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [PAGE_W-1:0]   rsp_evicted_page,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [APB_AW-1:0]   paddr,
   input  logic [APB_DW-1:0]   pwdata,
   output logic [APB_DW-1:0]   prdata,
   output logic                pready
);

   logic [EIU_W-1:0]  entries_in_use;
   logic [PAGE_W-1:0] page_limit;
   ctrl_cmd_type      cmd;
   dp_stat_type       stat;

   lpc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .entries_in_use (entries_in_use),
      .page_limit     (page_limit)
   );

   lpc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lpc_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_page_number  (req_page_number),
      .entries_in_use   (entries_in_use),
      .page_limit       (page_limit),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_evicted_page (rsp_evicted_page)
   );

endmodule

### test/lru_page_cache_policy_test.sv
// ----------------------------------------------------------------------------
// LRU page cache policy testbench
// Sends page requests through the start/busy command port and programs the
// entry and page limits over the APB port. A local copy of the tag store
// predicts status, slot and evicted page for every accepted request, and
// each strobed result is checked against the oldest prediction. A short
// directed part precedes several randomized phases with varied pacing.
// ----------------------------------------------------------------------------
module lru_page_cache_policy_test;
   import lpc_pkg::*;

   localparam int SLOTS           = CAPACITY_DEF;
   localparam int AGE_ALL         = SLOTS + 1;
   localparam int SETTLE_CYCLES   = 2 * SLOTS + 8;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int MAX_GAP         = 40;
   localparam int MAX_REPORTS     = 200;
   localparam longint TIMEOUT_CYCLES = 400000;

   localparam logic [APB_AW-1:0] ADDR_ENTRIES = {CSR_IDX_ENTRIES, 2'b00};
   localparam logic [APB_AW-1:0] ADDR_LIMIT   = {CSR_IDX_LIMIT, 2'b00};

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [PAGE_W-1:0]   evicted;
   } lookup_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [PAGE_W-1:0]   req_page_number = '0;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [APB_AW-1:0]   paddr = '0;
   logic [APB_DW-1:0]   pwdata = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [PAGE_W-1:0]   rsp_evicted_page;
   logic [APB_DW-1:0]   prdata;
   logic                pready;

   // Local copy of the tag store and its configuration.
   logic [PAGE_W-1:0] tag_copy [SLOTS];
   bit                held [SLOTS];
   int                age [SLOTS];
   int                fill_level = 0;
   logic [EIU_W-1:0]  cfg_entries = EIU_RESET;
   logic [PAGE_W-1:0] cfg_page_limit = '0;

   lookup_result_type pending_results [$];

   int idle_pct = 19;
   int n_errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_csr_writes = 0;
   int n_hits = 0;
   int n_fills = 0;
   int n_evicts = 0;
   int n_rejects = 0;

   lru_page_cache_policy #(.CAPACITY(SLOTS)) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_evicted_page (rsp_evicted_page),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void check_field(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         n_errors++;
         if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   function automatic int active_entries();
      int n;
      n = int'(cfg_entries);
      if (n == 0)
         n = 1;
      if (n > SLOTS)
         n = SLOTS;
      return n;
   endfunction

   // Entries more recent than the given age grow one step older.
   function automatic void promote_entry(input int s, input int below);
      for (int i = 0; i < SLOTS; i++)
         if (held[i] && i != s && age[i] < below)
            age[i]++;
      age[s] = 0;
   endfunction

   function automatic lookup_result_type predict_access(input logic [PAGE_W-1:0] page);
      lookup_result_type r;
      int s;
      int oldest;
      bit found;
      bit have_free;
      s = 0;
      oldest = -1;
      found = 1'b0;
      have_free = 1'b0;
      r.status = RS_HIT;
      r.evicted = '0;
      // The tag search comes before the range check, so a held page always hits.
      for (int i = 0; i < SLOTS; i++)
         if (!found && held[i] && tag_copy[i] == page) begin
            s = i;
            found = 1'b1;
         end
      if (found) begin
         promote_entry(s, age[s]);
         n_hits++;
      end else if (page == '0 || page > cfg_page_limit) begin
         r.status = RS_RANGE;
         s = 0;
         n_rejects++;
      end else begin
         if (fill_level < active_entries())
            for (int i = 0; i < SLOTS; i++)
               if (!have_free && !held[i]) begin
                  s = i;
                  have_free = 1'b1;
               end
         if (have_free) begin
            held[s] = 1'b1;
            tag_copy[s] = page;
            age[s] = 0;
            promote_entry(s, AGE_ALL);
            fill_level++;
            r.status = RS_FILL;
            n_fills++;
         end else begin
            // Oldest entry is the victim; the lowest slot wins a tie.
            for (int i = 0; i < SLOTS; i++)
               if (held[i] && (oldest < 0 || age[i] > oldest)) begin
                  oldest = age[i];
                  s = i;
               end
            if (oldest < 0) begin
               s = 0;
               held[0] = 1'b1;
               tag_copy[0] = page;
               age[0] = 0;
               fill_level = 1;
               r.status = RS_FILL;
               n_fills++;
            end else begin
               r.evicted = tag_copy[s];
               tag_copy[s] = page;
               promote_entry(s, AGE_ALL);
               r.status = RS_EVICT;
               n_evicts++;
            end
         end
      end
      r.slot = SLOT_W'(s);
      return r;
   endfunction

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
               $display("%0t: result with none expected, expected nothing, got %0h %0h %0h",
                        $time, rsp_status, rsp_slot, rsp_evicted_page);
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("slot", want.slot, rsp_slot);
            check_field("evicted page", want.evicted, rsp_evicted_page);
            n_checked++;
         end
      end
   end

   task automatic csr_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic program_register(input logic [APB_AW-1:0] addr,
                                   input logic [APB_DW-1:0] value);
      logic [APB_DW-1:0] readback;
      logic [APB_DW-1:0] stored;
      csr_write(addr, value);
      if (addr == ADDR_ENTRIES) begin
         cfg_entries = value[EIU_W-1:0];
         stored = APB_DW'(value[EIU_W-1:0]);
      end else begin
         cfg_page_limit = value;
         stored = value;
      end
      n_csr_writes++;
      csr_read(addr, readback);
      check_field("register readback", stored, readback);
   endtask

   task automatic send_page(input logic [PAGE_W-1:0] page);
      start <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_access(page));
      n_sent++;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
   endtask

   // Waits for every outstanding result, then lets the update sweep finish.
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      // The page limit resets to zero, so every request is out of range.
      send_page(32'd1);
      send_page('0);
      send_page('1);
      wait_for_results();
   endtask

   task automatic test_zero_entry_limit();
      program_register(ADDR_ENTRIES, '0);
      program_register(ADDR_LIMIT, '1);
      send_page(32'd7);
      send_page(32'd9);
      send_page(32'd7);
      wait_for_results();
   endtask

   task automatic test_fill_hit_evict();
      program_register(ADDR_ENTRIES, 32'd2);
      send_page('1);
      send_page(32'd1);
      send_page('0);
      send_page(32'd1);
      send_page(32'd5);
      send_page(32'h8000_0000);
      send_page(32'd5);
      wait_for_results();
   endtask

   task automatic test_limits_lowered();
      // Held pages above the new page limit still hit.
      program_register(ADDR_LIMIT, 32'd3);
      send_page(32'd5);
      send_page(32'd4);
      send_page(32'h8000_0000);
      wait_for_results();
      // Fill level now exceeds the entry limit, so misses must evict.
      program_register(ADDR_ENTRIES, 32'd1);
      send_page(32'd2);
      send_page(32'd3);
      wait_for_results();
   endtask

   task automatic test_oversized_entry_limit();
      program_register(ADDR_ENTRIES, 32'd31);
      program_register(ADDR_LIMIT, '1);
      send_page(32'h5555_5555);
      send_page(32'hAAAA_AAAA);
      send_page(32'd2);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      logic [PAGE_W-1:0] page;
      logic [PAGE_W-1:0] recent [$];
      logic [APB_DW-1:0] limit;
      logic [APB_DW-1:0] entries;
      int span;
      int pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_pct = (phase < 4) ? 19 : (phase < 7) ? 50 : 0;
         wait_for_results();
         case (phase % 5)
            0: entries = 32'd16;
            1: entries = 32'd31;
            2: entries = 32'd1;
            3: entries = 32'd0;
            default: entries = $urandom_range(15, 2);
         endcase
         case (phase % 3)
            0: limit = '1;
            1: limit = $urandom_range(48, 12);
            default: limit = $urandom;
         endcase
         program_register(ADDR_ENTRIES, entries);
         program_register(ADDR_LIMIT, limit);
         span = (limit < 40) ? int'(limit) : 40;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            // Mostly reuse recent pages and a small working set to get hits.
            if (pick < 45 && recent.size() != 0)
               page = recent[$urandom_range(recent.size() - 1)];
            else if (pick < 72 && span > 0)
               page = $urandom_range(span, 1);
            else if (pick < 82) begin
               case ($urandom_range(3))
                  0: page = '0;
                  1: page = limit;
                  2: page = limit + 1;
                  default: page = '1;
               endcase
            end else
               page = $urandom;
            send_page(page);
            recent.push_back(page);
            if (recent.size() > 24)
               void'(recent.pop_front());
            if ((phase == 0 && n == 40) || $urandom_range(99) == 0)
               wait_for_results();
         end
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tag_copy[i] = '0;
         held[i] = 1'b0;
         age[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_zero_entry_limit();
      test_fill_hit_evict();
      test_limits_lowered();
      test_oversized_entry_limit();
      test_random_traffic();
      wait_for_results();
      $display("Sent %0d page requests under %0d register writes; %0d results checked.",
               n_sent, n_csr_writes, n_checked);
      $display("Outcomes: %0d hits, %0d fills, %0d evictions, %0d out of range.",
               n_hits, n_fills, n_evicts, n_rejects);
      if (n_errors == 0 && pending_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #(20 * TIMEOUT_CYCLES);
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
